/* rtl/gie_pkg.sv */
// ----------------------------------------------------------------------------
// gie_pkg: shared definitions for the grouped int8 embedding lookup
// Default sizes, request codes, register indexes, reset values, fp16 constants and op kinds.
// ----------------------------------------------------------------------------
`default_nettype none

package gie_pkg;

  // Default sizing of the weight and scale stores.
  localparam int unsigned MAX_ROWS_DEF   = 1024;
  localparam int unsigned MAX_HIDDEN_DEF = 256;
  localparam int unsigned MAX_GROUPS_DEF = 16;

  // Request function codes.
  localparam logic [1:0] FUNC_WEIGHT_WR = 2'd0;
  localparam logic [1:0] FUNC_SCALE_WR  = 2'd1;
  localparam logic [1:0] FUNC_LOOKUP    = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] CFG_ROW_COUNT   = 2'd0;
  localparam logic [1:0] CFG_ROW_COLS    = 2'd1;
  localparam logic [1:0] CFG_GRP_COLS    = 2'd2;
  localparam logic [1:0] CFG_GROUP_COUNT = 2'd3;

  // Register reset values.
  localparam logic [10:0] ROW_COUNT_RST   = 11'd1024;
  localparam logic [8:0]  ROW_COLS_RST    = 9'd256;
  localparam logic [8:0]  GRP_COLS_RST    = 9'd64;
  localparam logic [4:0]  GROUP_COUNT_RST = 5'd4;

  // fp16 patterns.
  localparam logic [15:0] FP16_INF     = 16'h7C00;
  localparam logic [15:0] FP16_QNAN    = 16'h7E00;
  localparam logic [15:0] FP16_QUIET   = 16'h0200;
  localparam logic [4:0]  FP16_EXP_MAX = 5'd31;

  // Operation travelling down the pipeline.
  typedef enum logic [1:0] {
    OP_WEIGHT_WR,
    OP_SCALE_WR,
    OP_BEAT,
    OP_OOB
  } op_kind_t;

endpackage

`default_nettype wire

/* rtl/grouped_int8_embedding_lookup_top.sv */
// ----------------------------------------------------------------------------
// grouped_int8_embedding_lookup_top: int8 embedding table with fp16 scales
// Stores int8 weights and fp16 group scales, and streams dequantised rows.
// ----------------------------------------------------------------------------
// Usage. The input channel (in_valid / in_stall) carries one request: a weight
// byte write, a scale write or a token lookup, selected by func. The output
// channel (out_valid / out_stall) returns four fp16 columns per result;
// last_beat marks the final result of a lookup. The configuration channel
// (cfg_valid / cfg_ready, always ready) sets row_count, row_cols, grp_cols
// and group_count; it is to be written only while the block is idle, which
// the block itself does not enforce. A lookup occupies the sequencer for an
// address step and then a walk over its beats (row_cols/4 beats, capped at
// MAX_HIDDEN/4), and no new request is taken until the walk ends; an
// out-of-bounds token gives one result. The first result of a lookup passes
// through address, issue, memory read, multiply, normalise and pack. The
// four-column weight read and the four scale reads per beat set the one beat
// per cycle rate while out_stall is low.
// Reset clears control state and loads the register defaults; the stores are
// not cleared. While out_stall holds a result, the whole pipeline freezes and
// in_stall rises; nothing is lost or repeated.
// ----------------------------------------------------------------------------
`default_nettype none

module grouped_int8_embedding_lookup_top #(
  parameter int unsigned MAX_ROWS   = gie_pkg::MAX_ROWS_DEF,
  parameter int unsigned MAX_HIDDEN = gie_pkg::MAX_HIDDEN_DEF,
  parameter int unsigned MAX_GROUPS = gie_pkg::MAX_GROUPS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // Configuration write channel.
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [10:0] cfg_data,
  // Request channel.
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  func,
  input  wire logic [17:0] write_addr,
  input  wire logic [15:0] write_data,
  input  wire logic [15:0] token,
  // Result channel.
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [15:0]      value0,
  output logic [15:0]      value1,
  output logic [15:0]      value2,
  output logic [15:0]      value3,
  output logic             last_beat,
  output logic             out_of_bounds
);

  import gie_pkg::*;

  localparam int unsigned WDEPTH = MAX_ROWS * MAX_HIDDEN;
  localparam int unsigned SDEPTH = MAX_ROWS * MAX_GROUPS;
  localparam int unsigned WAW    = $clog2(WDEPTH);
  localparam int unsigned SAW    = $clog2(SDEPTH);
  localparam int unsigned WWORDS = WDEPTH / 4;
  localparam int unsigned CAP    = MAX_HIDDEN / 4;
  localparam int unsigned BW     = $clog2(CAP + 1);
  localparam int unsigned BLW    = 14;
  localparam int unsigned WBW    = BLW + BW;
  localparam int unsigned SBW    = BLW + 5;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_RUN
  } state_t;

  // Configuration registers.
  logic [10:0] row_count;
  logic [8:0]  row_cols;
  logic [8:0]  grp_cols;
  logic [4:0]  group_count;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_count   <= ROW_COUNT_RST;
      row_cols    <= ROW_COLS_RST;
      grp_cols    <= GRP_COLS_RST;
      group_count <= GROUP_COUNT_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_ROW_COUNT:   row_count   <= cfg_data;
        CFG_ROW_COLS:    row_cols    <= cfg_data[8:0];
        CFG_GRP_COLS:    grp_cols    <= cfg_data[8:0];
        CFG_GROUP_COUNT: group_count <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  // Whole pipeline moves together unless a held result is stalled.
  logic adv;
  assign adv = !out_valid || !out_stall;

  // Beat count of a lookup, capped at the store width.
  logic [6:0]    hd4;
  logic [BW-1:0] nb_in;
  assign hd4   = row_cols[8:2];
  assign nb_in = (hd4 > 7'(CAP)) ? BW'(CAP) : BW'(hd4);

  // Sequencer registers.
  state_t         state;
  logic [BLW-1:0] blk;
  logic [1:0]     lane;
  logic [BW-1:0]  nb;
  logic [BW-1:0]  beat;
  logic [WBW-1:0] wbase;
  logic [SBW-1:0] sbase;
  logic [8:0]     grp;
  logic [8:0]     off;

  logic in_acc;
  assign in_stall = (state != ST_IDLE) || !adv;
  assign in_acc   = in_valid && !in_stall;

  logic tok_oob;
  assign tok_oob = token >= {5'b0, row_count};

  // Column group tracking: a chain of four single-column steps per beat.
  logic [8:0] cg [4];
  logic [8:0] grp_next;
  logic [8:0] off_next;
  logic [3:0] cmask;

  always_comb begin
    logic [8:0] g_w;
    logic [8:0] o_w;
    logic [8:0] o_inc;
    g_w = grp;
    o_w = off;
    for (int j = 0; j < 4; j++) begin
      cg[j]    = g_w;
      cmask[j] = g_w < {4'b0, group_count};
      o_inc    = o_w + 9'd1;
      if ((grp_cols != 9'd0) && (o_inc == grp_cols)) begin
        g_w = g_w + 9'd1;
        o_w = 9'd0;
      end else begin
        o_w = o_inc;
      end
    end
    grp_next = g_w;
    off_next = o_w;
  end

  // Addresses of the current beat.
  logic [31:0]    wword_full;
  logic [31:0]    saddr_full [4];
  logic [WBW-1:0] wsum;
  logic [31:0]    wr_full;

  assign wsum       = wbase + WBW'(beat);
  assign wword_full = {(32 - WBW - 2)'(0), wsum, lane};
  assign wr_full    = {14'b0, write_addr};

  always_comb begin
    for (int j = 0; j < 4; j++) begin
      saddr_full[j] = (((32'(sbase) + 32'(cg[j])) << 2) | 32'(lane));
    end
  end

  // Operation issued by the sequencer this cycle.
  logic              emit_v;
  op_kind_t          emit_kind;
  logic [WAW-3:0]    emit_waddr;
  logic [1:0]        emit_bank;
  logic [SAW-1:0]    emit_saddr [4];
  logic [3:0]        emit_cmask;
  logic              emit_last;
  logic              beat_last;

  assign beat_last = (BW'(beat + BW'(1)) == nb);

  always_comb begin
    emit_v     = 1'b0;
    emit_kind  = OP_BEAT;
    emit_waddr = wword_full[WAW-3:0];
    emit_bank  = wr_full[1:0];
    emit_cmask = cmask;
    emit_last  = beat_last;
    for (int j = 0; j < 4; j++) begin
      emit_saddr[j] = saddr_full[j][SAW-1:0];
    end
    unique case (state)
      ST_IDLE: begin
        if (in_acc) begin
          priority if (func == FUNC_WEIGHT_WR) begin
            emit_v     = 1'b1;
            emit_kind  = OP_WEIGHT_WR;
            emit_waddr = wr_full[WAW-1:2];
          end else if (func == FUNC_SCALE_WR) begin
            emit_v        = 1'b1;
            emit_kind     = OP_SCALE_WR;
            emit_saddr[0] = wr_full[SAW-1:0];
          end else if ((func == FUNC_LOOKUP) && tok_oob) begin
            emit_v     = 1'b1;
            emit_kind  = OP_OOB;
            emit_cmask = 4'b0;
            emit_last  = 1'b1;
          end else begin
            // In-range lookups with a nonzero beat count start the sequencer; others and unused codes are dropped.
            emit_v = 1'b0;
          end
        end
      end
      ST_MUL: ;
      ST_RUN: emit_v = 1'b1;
      default: ;
    endcase
  end

  // Sequencer: takes a request, forms the row bases, then walks the beats.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (in_acc && (func == FUNC_LOOKUP) && !tok_oob && (nb_in != BW'(0))) begin
            blk   <= token[15:2];
            lane  <= token[1:0];
            nb    <= nb_in;
            state <= ST_MUL;
          end
        end
        ST_MUL: begin
          wbase <= WBW'(blk) * WBW'(nb);
          sbase <= SBW'(blk) * SBW'(group_count);
          beat  <= BW'(0);
          grp   <= 9'd0;
          off   <= 9'd0;
          state <= ST_RUN;
        end
        ST_RUN: begin
          if (adv) begin
            beat <= beat + BW'(1);
            grp  <= grp_next;
            off  <= off_next;
            if (beat_last) begin
              state <= ST_IDLE;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Stage 1: address stage.
  logic           s1_v;
  op_kind_t       s1_kind;
  logic [WAW-3:0] s1_waddr;
  logic [1:0]     s1_bank;
  logic [15:0]    s1_wdata;
  logic [SAW-1:0] s1_saddr [4];
  logic [3:0]     s1_cmask;
  logic           s1_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
    end else if (adv) begin
      s1_v <= emit_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_kind  <= emit_kind;
      s1_waddr <= emit_waddr;
      s1_bank  <= emit_bank;
      s1_wdata <= write_data;
      s1_cmask <= emit_cmask;
      s1_last  <= emit_last;
      for (int j = 0; j < 4; j++) begin
        s1_saddr[j] <= emit_saddr[j];
      end
    end
  end

  // Stage 2: store access. Four weight byte banks, four scale copies.
  logic        s2_v;
  op_kind_t    s2_kind;
  logic [3:0]  s2_cmask;
  logic        s2_last;
  logic [7:0]  s2_w [4];
  logic [15:0] s2_s [4];

  for (genvar j = 0; j < 4; j++) begin : g_store
    logic [7:0]  wmem [WWORDS];
    logic [15:0] smem [SDEPTH];

    always_ff @(posedge clk) begin
      if (adv) begin
        if (s1_v && (s1_kind == OP_WEIGHT_WR) && (s1_bank == 2'(j))) begin
          wmem[s1_waddr] <= s1_wdata[7:0];
        end
        s2_w[j] <= wmem[s1_waddr];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        if (s1_v && (s1_kind == OP_SCALE_WR)) begin
          smem[s1_saddr[0]] <= s1_wdata;
        end
        s2_s[j] <= smem[s1_saddr[j]];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_v <= 1'b0;
    end else if (adv) begin
      s2_v <= s1_v && ((s1_kind == OP_BEAT) || (s1_kind == OP_OOB));
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_kind  <= s1_kind;
      s2_cmask <= s1_cmask;
      s2_last  <= s1_last;
    end
  end

  // Stage 3: magnitude times significand; special scales resolved here.
  logic        s3_v;
  op_kind_t    s3_kind;
  logic        s3_last;
  logic [17:0] s3_p    [4];
  logic [4:0]  s3_sh   [4];
  logic        s3_sign [4];
  logic        s3_spec [4];
  logic [15:0] s3_sval [4];

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_v <= 1'b0;
    end else if (adv) begin
      s3_v <= s2_v;
    end
  end

  always_ff @(posedge clk) begin
    logic [7:0]  mag;
    logic [4:0]  ex;
    logic [10:0] sig;
    logic        sgn;
    if (adv) begin
      s3_kind <= s2_kind;
      s3_last <= s2_last;
      for (int j = 0; j < 4; j++) begin
        mag = s2_w[j][7] ? 8'(-s2_w[j]) : s2_w[j];
        ex  = s2_s[j][14:10];
        sig = (ex == 5'd0) ? {1'b0, s2_s[j][9:0]} : {1'b1, s2_s[j][9:0]};
        sgn = s2_s[j][15] ^ s2_w[j][7];
        s3_p[j]    <= 18'(mag) * 18'(sig);
        s3_sh[j]   <= (ex == 5'd0) ? 5'd0 : ex - 5'd1;
        s3_sign[j] <= sgn;
        priority if (!s2_cmask[j]) begin
          s3_spec[j] <= 1'b1;
          s3_sval[j] <= 16'h0000;
        end else if ((ex == FP16_EXP_MAX) && (s2_s[j][9:0] != 10'd0)) begin
          s3_spec[j] <= 1'b1;
          s3_sval[j] <= s2_s[j] | FP16_QUIET;
        end else if ((ex == FP16_EXP_MAX) && (mag == 8'd0)) begin
          s3_spec[j] <= 1'b1;
          s3_sval[j] <= FP16_QNAN;
        end else if (ex == FP16_EXP_MAX) begin
          s3_spec[j] <= 1'b1;
          s3_sval[j] <= {sgn, 15'd0} | FP16_INF;
        end else begin
          s3_spec[j] <= 1'b0;
          s3_sval[j] <= 16'h0000;
        end
      end
    end
  end

  // Stage 4: normalise the product and round to eleven bits.
  logic        s4_v;
  op_kind_t    s4_kind;
  logic        s4_last;
  logic        s4_direct [4];
  logic [15:0] s4_dval   [4];
  logic [11:0] s4_m12    [4];
  logic [5:0]  s4_eb     [4];
  logic        s4_sign   [4];

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_v <= 1'b0;
    end else if (adv) begin
      s4_v <= s3_v;
    end
  end

  always_ff @(posedge clk) begin
    logic [4:0]  msb;
    logic [17:0] n;
    logic        rnd;
    if (adv) begin
      s4_kind <= s3_kind;
      s4_last <= s3_last;
      for (int j = 0; j < 4; j++) begin
        msb = 5'd0;
        for (int k = 0; k < 18; k++) begin
          if (s3_p[j][k]) begin
            msb = 5'(k);
          end
        end
        n   = s3_p[j] << (5'd17 - msb);
        rnd = n[6] && ((|n[5:0]) || n[7]);
        s4_sign[j] <= s3_sign[j];
        s4_m12[j]  <= {1'b0, n[17:7]} + 12'(rnd);
        s4_eb[j]   <= 6'(msb) + 6'(s3_sh[j]) - 6'd9;
        priority if (s3_spec[j]) begin
          s4_direct[j] <= 1'b1;
          s4_dval[j]   <= s3_sval[j];
        end else if ((s3_p[j] == 18'd0) || ((s3_sh[j] == 5'd0) && (s3_p[j] < 18'd2048))) begin
          s4_direct[j] <= 1'b1;
          s4_dval[j]   <= {s3_sign[j], 4'b0, s3_p[j][10:0]};
        end else begin
          s4_direct[j] <= 1'b0;
          s4_dval[j]   <= 16'h0000;
        end
      end
    end
  end

  // Stage 5: pack into fp16 and hold for the receiver.
  logic [15:0] vpack [4];

  always_comb begin
    logic [5:0] e;
    logic [9:0] m;
    for (int j = 0; j < 4; j++) begin
      e = s4_m12[j][11] ? s4_eb[j] + 6'd1 : s4_eb[j];
      m = s4_m12[j][11] ? 10'd0 : s4_m12[j][9:0];
      priority if (s4_direct[j]) begin
        vpack[j] = s4_dval[j];
      end else if (e >= 6'(FP16_EXP_MAX)) begin
        vpack[j] = {s4_sign[j], 15'd0} | FP16_INF;
      end else begin
        vpack[j] = {s4_sign[j], e[4:0], m};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= s4_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      value0        <= vpack[0];
      value1        <= vpack[1];
      value2        <= vpack[2];
      value3        <= vpack[3];
      last_beat     <= s4_last;
      out_of_bounds <= (s4_kind == OP_OOB);
    end
  end

`ifndef NO_ASSERTIONS
  // Requests are refused while a lookup is being walked.
  a_busy_stall: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> in_stall)
    else $error("request taken while sequencer busy");

  // An out-of-bounds result is always the only, and so last, result.
  a_oob_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_of_bounds) |-> last_beat)
    else $error("out-of-bounds result without last_beat");

  // An out-of-bounds result carries zero values.
  a_oob_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_of_bounds) |->
      ((value0 == 16'h0) && (value1 == 16'h0) && (value2 == 16'h0) && (value3 == 16'h0)))
    else $error("out-of-bounds result with non-zero values");

  // The beat counter stays inside the row while walking.
  a_beat_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RUN) |-> (beat < nb))
    else $error("beat counter beyond row width");

  // The row walk starts right after the base products are formed.
  a_mul_run: assert property (@(posedge clk) disable iff (rst)
    (state == ST_MUL) |=> (state == ST_RUN))
    else $error("address cycle not followed by beat walk");
`endif

endmodule

`default_nettype wire
